>>> sv/gqn_pkg.sv
// gqn_pkg: shared constants, operation codes and controller/datapath
// interface structs for the groove quantizer. No dependencies.
`default_nettype none
package gqn_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int POS_W       = 32;
    localparam int VEL_W       = 7;
    localparam int STR_W       = 9;
    localparam int PROD_W      = POS_W + STR_W;
    localparam int STR_FRAC    = 8;

    localparam logic [STR_W-1:0] STR_RESET = 9'd256;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUANT = 2'd2;

    localparam logic REG_POS_STR = 1'b0;
    localparam logic REG_VEL_STR = 1'b1;

    typedef struct packed {
        logic cap;
        logic scan;
        logic mul;
        logic fin;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> sv/groove_quantize_note.sv
// groove_quantize_note: top level of the groove quantizer.
// Depends on gqn_pkg, gqn_regs, gqn_ctrl, gqn_dp.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   operation, position, velocity,
//                                                has_velocity, max_distance,
//                                                window_start, window_end
// output    out        o_out_valid / i_out_stall new_position, new_velocity,
//                                                moved, load_status
// config    in         APB psel/penable/pwrite   pos_strength @0, vel_strength @4
//
// Quantize: the scan reads one table entry per cycle from the groove memory,
// then the multiply and finish steps run; clear and load skip all three.
// One transaction in flight; the output register lets the next one start
// while a result waits. Reset clears the point count and output valid and
// sets both strengths to 256; table contents are not cleared.
`default_nettype none
module groove_quantize_note
    import gqn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_operation,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [VEL_W-1:0]  i_velocity,
    input  wire logic              i_has_velocity,
    input  wire logic [POS_W-1:0]  i_max_distance,
    input  wire logic [POS_W-1:0]  i_window_start,
    input  wire logic [POS_W-1:0]  i_window_end,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [POS_W-1:0]  o_new_position,
    output logic      [VEL_W-1:0]  o_new_velocity,
    output logic                   o_moved,
    output logic                   o_load_status
);

    logic [STR_W-1:0] w_pos_str;
    logic [STR_W-1:0] w_vel_str;
    t_cmd             w_cmd;
    t_sts             w_sts;

    gqn_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_pos_str (w_pos_str),
        .o_vel_str (w_vel_str)
    );

    gqn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_sts       (w_sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (w_cmd)
    );

    gqn_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_pos_str      (w_pos_str),
        .i_vel_str      (w_vel_str),
        .i_operation    (i_operation),
        .i_position     (i_position),
        .i_velocity     (i_velocity),
        .i_has_velocity (i_has_velocity),
        .i_max_distance (i_max_distance),
        .i_window_start (i_window_start),
        .i_window_end   (i_window_end),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_new_position (o_new_position),
        .o_new_velocity (o_new_velocity),
        .o_moved        (o_moved),
        .o_load_status  (o_load_status)
    );

endmodule
`default_nettype wire

>>> sv/gqn_regs.sv
// gqn_regs: APB configuration registers (position and velocity strength).
// Depends on gqn_pkg.
`default_nettype none
module gqn_regs
    import gqn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output logic      [STR_W-1:0] o_pos_str,
    output logic      [STR_W-1:0] o_vel_str
);

    logic [STR_W-1:0] r_pos_str;
    logic [STR_W-1:0] r_vel_str;
    logic             w_wr;

    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_str <= STR_RESET;
            r_vel_str <= STR_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_POS_STR) begin
                r_pos_str <= pwdata[STR_W-1:0];
            end else begin
                r_vel_str <= pwdata[STR_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_POS_STR) begin
            prdata = {{(32-STR_W){1'b0}}, r_pos_str};
        end else begin
            prdata = {{(32-STR_W){1'b0}}, r_vel_str};
        end
    end

    assign o_pos_str = r_pos_str;
    assign o_vel_str = r_vel_str;

endmodule
`default_nettype wire

>>> sv/gqn_ctrl.sv
// gqn_ctrl: sequencing state machine for the groove quantizer.
// Depends on gqn_pkg; drives t_cmd, reads t_sts from gqn_dp.
`default_nettype none
module gqn_ctrl
    import gqn_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_operation,
    input  wire t_sts       i_sts,
    output logic            o_in_stall,
    output t_cmd            o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = (i_operation == OP_QUANT) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

>>> sv/gqn_dp.sv
// gqn_dp: groove table memory, nearest-point scan, pull and velocity blend
// arithmetic, output register. Depends on gqn_pkg; commanded by gqn_ctrl.
`default_nettype none
module gqn_dp
    import gqn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    input  wire logic [STR_W-1:0] i_pos_str,
    input  wire logic [STR_W-1:0] i_vel_str,
    input  wire logic [1:0]       i_operation,
    input  wire logic [POS_W-1:0] i_position,
    input  wire logic [VEL_W-1:0] i_velocity,
    input  wire logic             i_has_velocity,
    input  wire logic [POS_W-1:0] i_max_distance,
    input  wire logic [POS_W-1:0] i_window_start,
    input  wire logic [POS_W-1:0] i_window_end,
    input  wire logic             i_out_stall,
    output logic                  o_out_valid,
    output logic      [POS_W-1:0] o_new_position,
    output logic      [VEL_W-1:0] o_new_velocity,
    output logic                  o_moved,
    output logic                  o_load_status
);

    localparam int ENT_W = POS_W + 8;

    logic [ENT_W-1:0] mem [TABLE_DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_addr;
    logic             r_rd_vld;
    logic [ENT_W-1:0] r_rdata;

    logic [POS_W-1:0] r_pos;
    logic [VEL_W-1:0] r_vel;
    logic [POS_W-1:0] r_wstart;
    logic [POS_W-1:0] r_wend;

    logic [POS_W-1:0] r_best;
    logic [7:0]       r_best_vel;
    logic             r_positive;
    logic             r_found;

    logic [PROD_W-1:0]  r_pprod;
    logic signed [18:0] r_vprod;

    logic [POS_W-1:0] r_res_pos;
    logic [VEL_W-1:0] r_res_vel;
    logic             r_res_moved;
    logic             r_res_ls;

    logic             r_o_valid;
    logic [POS_W-1:0] r_o_pos;
    logic [VEL_W-1:0] r_o_vel;
    logic             r_o_moved;
    logic             r_o_ls;

    logic             w_full;
    logic             w_wr;
    logic             w_rd;
    logic [POS_W-1:0] w_rpos;
    logic [POS_W-1:0] w_dist;
    logic             w_out_free;

    logic signed [7:0]  w_vdiff;
    logic signed [18:0] w_vs_s;
    logic signed [18:0] w_diff_s;

    logic [PROD_W-STR_FRAC-1:0] w_move;
    logic signed [34:0] w_target;
    logic               w_in_win;
    logic signed [18:0] w_vadj;
    logic signed [10:0] w_vchg;
    logic signed [10:0] w_vsum;
    logic [VEL_W-1:0]   w_vclamp;

    assign w_full = (r_count >= CNT_W'(TABLE_DEPTH));
    assign w_wr   = i_cmd.cap && (i_operation == OP_LOAD) && !w_full;
    assign w_rd   = i_cmd.scan && (r_addr < r_count);

    // table memory
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[r_count[IDX_W-1:0]] <= {i_has_velocity, i_velocity, i_position};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rdata <= mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cap && (i_operation == OP_CLEAR)) begin
            r_count <= '0;
        end else if (w_wr) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // scan
    assign w_rpos = r_rdata[POS_W-1:0];
    assign w_dist = (r_pos >= w_rpos) ? (r_pos - w_rpos) : (w_rpos - r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
            r_found  <= 1'b0;
        end else if (i_cmd.cap) begin
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
            r_found  <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= w_rd;
            if (w_rd) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (r_rd_vld && (w_dist < r_best)) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pos    <= i_position;
            r_vel    <= i_velocity;
            r_wstart <= i_window_start;
            r_wend   <= i_window_end;
            r_best   <= i_max_distance;
        end else if (i_cmd.scan && r_rd_vld && (w_dist < r_best)) begin
            r_best     <= w_dist;
            r_best_vel <= r_rdata[ENT_W-1:POS_W];
            r_positive <= (r_pos > w_rpos);
        end
    end

    assign o_sts.scan_done = (r_addr == r_count) && !r_rd_vld;

    // multiply
    assign w_vdiff  = $signed({1'b0, r_best_vel[VEL_W-1:0]}) - $signed({1'b0, r_vel});
    assign w_vs_s   = $signed({10'd0, i_vel_str});
    assign w_diff_s = 19'(w_vdiff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_pprod <= PROD_W'(r_best) * PROD_W'(i_pos_str);
            r_vprod <= w_vs_s * w_diff_s + 19'sd128;
        end
    end

    // pull, window test, velocity blend
    assign w_move   = r_pprod[PROD_W-1:STR_FRAC];
    assign w_target = r_positive ? ($signed({3'b0, r_pos}) - $signed({2'b0, w_move}))
                                 : ($signed({3'b0, r_pos}) + $signed({2'b0, w_move}));
    assign w_in_win = (w_target >= $signed({3'b0, r_wstart}))
                   && (w_target <  $signed({3'b0, r_wend}));
    assign w_vadj   = r_vprod[18] ? (r_vprod + 19'sd255) : r_vprod;
    assign w_vchg   = w_vadj[18:8];
    assign w_vsum   = $signed({4'b0, r_vel}) + w_vchg;

    always_comb begin
        if (w_vsum[10]) begin
            w_vclamp = '0;
        end else if (w_vsum > 11'sd127) begin
            w_vclamp = 7'd127;
        end else begin
            w_vclamp = w_vsum[VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_res_pos   <= '0;
            r_res_vel   <= '0;
            r_res_moved <= 1'b0;
            r_res_ls    <= (i_operation == OP_LOAD) && w_full;
        end else if (i_cmd.fin) begin
            if (r_found && w_in_win) begin
                r_res_pos   <= w_target[POS_W-1:0];
                r_res_vel   <= r_best_vel[7] ? w_vclamp : r_vel;
                r_res_moved <= 1'b1;
            end else begin
                r_res_pos   <= r_pos;
                r_res_vel   <= r_vel;
                r_res_moved <= 1'b0;
            end
        end
    end

    // output register
    assign w_out_free     = !r_o_valid || !i_out_stall;
    assign o_sts.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_pos   <= r_res_pos;
            r_o_vel   <= r_res_vel;
            r_o_moved <= r_res_moved;
            r_o_ls    <= r_res_ls;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_new_position = r_o_pos;
    assign o_new_velocity = r_o_vel;
    assign o_moved        = r_o_moved;
    assign o_load_status  = r_o_ls;

endmodule
`default_nettype wire
